### hdl/me_pkg.sv
package me_pkg;

    localparam int FIELD_W   = 32;
    localparam int WIDTH_DEF = 32;
    localparam int PC_W      = 3;

    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_REDUCE,
        OP_MUL_ACC,
        OP_MUL_SQ,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_EXP_ZERO,
        COND_BIT_CLEAR,
        COND_EXP_DONE
    } t_cond;

    typedef enum logic {
        DST_SQ,
        DST_ACC
    } t_dst;

    typedef struct packed {
        t_op   op;
        t_dst  dst;
        t_cond cond;
        t_pc   target;
    } t_uword;

    localparam t_pc PC_WAIT    = t_pc'(0);
    localparam t_pc PC_RED_B   = t_pc'(1);
    localparam t_pc PC_MUL_ACC = t_pc'(2);
    localparam t_pc PC_RED_ACC = t_pc'(3);
    localparam t_pc PC_MUL_SQ  = t_pc'(4);
    localparam t_pc PC_RED_SQ  = t_pc'(5);
    localparam t_pc PC_EMIT    = t_pc'(6);

    // square and multiply program, exponent scanned from its low bit
    function automatic t_uword ucode_rom(t_pc pc);
        t_uword w;
        unique case (pc)
            PC_WAIT:    w = '{OP_WAIT,    DST_SQ,  COND_EXP_ZERO,  PC_EMIT};
            PC_RED_B:   w = '{OP_REDUCE,  DST_SQ,  COND_NONE,      PC_WAIT};
            PC_MUL_ACC: w = '{OP_MUL_ACC, DST_SQ,  COND_BIT_CLEAR, PC_MUL_SQ};
            PC_RED_ACC: w = '{OP_REDUCE,  DST_ACC, COND_NONE,      PC_WAIT};
            PC_MUL_SQ:  w = '{OP_MUL_SQ,  DST_SQ,  COND_EXP_DONE,  PC_EMIT};
            PC_RED_SQ:  w = '{OP_REDUCE,  DST_SQ,  COND_ALWAYS,    PC_MUL_ACC};
            PC_EMIT:    w = '{OP_EMIT,    DST_SQ,  COND_ALWAYS,    PC_WAIT};
            default:    w = '{OP_WAIT,    DST_SQ,  COND_ALWAYS,    PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

### hdl/me_if.sv
interface me_in_if;
    import me_pkg::*;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] base_value;
    logic [FIELD_W-1:0] exponent_value;
    logic [FIELD_W-1:0] modulus;

    modport source (output valid, output base_value, output exponent_value,
                    output modulus, input ready);
    modport sink   (input valid, input base_value, input exponent_value,
                    input modulus, output ready);
endinterface

interface me_out_if;
    import me_pkg::*;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);
endinterface

### hdl/modular_exponentiation_top.sv
// channel  dir  handshake          payload
// i_in     in   valid/ready        base_value, exponent_value, modulus (32b each)
// o_out    out  valid/ready        power_result (32b)
//
// one item at a time; a zero exponent goes straight to emit, which registers the result
// otherwise each exponent bit up to the highest set one costs a multiply into the accumulator
// if the bit is set and, below the highest bit, a squaring, each then reduced by the bit-serial
// remainder unit at one product bit per cycle; a zero modulus skips that bit-serial work
// synchronous active-low reset returns the sequencer to its wait step
// a finished result sits in the output register while the next item is accepted
module modular_exponentiation_top
    import me_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    me_in_if.sink     i_in,
    me_out_if.source  o_out
);

    localparam int PROD_W = 2 * WIDTH;
    localparam int CNT_W  = $clog2(PROD_W);
    localparam logic [CNT_W-1:0] RED_LAST = CNT_W'(PROD_W - 1);

    t_pc                r_pc, n_pc;
    t_uword             uw;
    logic [WIDTH-1:0]   r_acc, r_sq, r_mod, r_exp;
    logic [PROD_W-1:0]  r_prod;
    logic [WIDTH:0]     r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_valid;
    logic [WIDTH-1:0]   r_out_data;

    logic               in_fire, out_fire, out_space;
    logic [WIDTH-1:0]   in_base, in_exp, in_mod;
    logic [WIDTH:0]     rem_shift, rem_next;
    logic               red_done;
    logic [WIDTH-1:0]   red_value;
    logic [WIDTH-1:0]   mul_a;
    logic [PROD_W-1:0]  mul_p;
    logic               step_hold, cond_true;

    assign uw        = ucode_rom(r_pc);
    assign in_fire   = i_in.valid && i_in.ready;
    assign out_fire  = r_out_valid && o_out.ready;
    assign out_space = !r_out_valid || o_out.ready;
    assign in_base   = i_in.base_value[WIDTH-1:0];
    assign in_exp    = i_in.exponent_value[WIDTH-1:0];
    assign in_mod    = i_in.modulus[WIDTH-1:0];

    // restoring remainder, one product bit per cycle
    assign rem_shift = {r_rem[WIDTH-1:0], r_prod[PROD_W-1]};
    assign rem_next  = (rem_shift >= {1'b0, r_mod}) ? rem_shift - {1'b0, r_mod} : rem_shift;
    // zero modulus wraps, so the low half of the product is the answer at once
    assign red_done  = (r_mod == '0) || (r_cnt == RED_LAST);
    assign red_value = (r_mod == '0) ? r_prod[WIDTH-1:0] : rem_next[WIDTH-1:0];

    assign mul_a = (uw.op == OP_MUL_SQ) ? r_sq : r_acc;
    assign mul_p = mul_a * r_sq;

    // sequencer
    always_comb begin
        unique case (uw.op)
            OP_WAIT:   step_hold = !in_fire;
            OP_REDUCE: step_hold = !red_done;
            OP_EMIT:   step_hold = !out_space;
            default:   step_hold = 1'b0;
        endcase
        unique case (uw.cond)
            COND_NONE:      cond_true = 1'b0;
            COND_ALWAYS:    cond_true = 1'b1;
            COND_EXP_ZERO:  cond_true = (in_exp == '0);
            COND_BIT_CLEAR: cond_true = !r_exp[0];
            COND_EXP_DONE:  cond_true = (r_exp[WIDTH-1:1] == '0);
            default:        cond_true = 1'b0;
        endcase
    end

    always_comb begin
        priority if (step_hold) begin
            n_pc = r_pc;
        end else if (cond_true) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_WAIT;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (uw.op == OP_EMIT && out_space) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (uw.op)
            OP_WAIT: begin
                if (in_fire) begin
                    r_prod <= {{WIDTH{1'b0}}, in_base};
                    r_exp  <= in_exp;
                    r_mod  <= in_mod;
                    r_acc  <= WIDTH'(1);
                    r_rem  <= '0;
                    r_cnt  <= '0;
                end
            end
            OP_REDUCE: begin
                r_prod <= r_prod << 1;
                r_rem  <= rem_next;
                r_cnt  <= r_cnt + 1'b1;
                if (red_done) begin
                    if (uw.dst == DST_ACC) begin
                        r_acc <= red_value;
                    end else begin
                        r_sq <= red_value;
                    end
                end
            end
            OP_MUL_ACC: begin
                r_prod <= mul_p;
                r_rem  <= '0;
                r_cnt  <= '0;
            end
            OP_MUL_SQ: begin
                r_prod <= mul_p;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_exp  <= r_exp >> 1;
            end
            OP_EMIT: begin
                if (out_space) begin
                    r_out_data <= r_acc;
                end
            end
            default: begin
            end
        endcase
    end

    assign i_in.ready         = (uw.op == OP_WAIT);
    assign o_out.valid        = r_out_valid;
    assign o_out.power_result = FIELD_W'(r_out_data);

`ifndef NO_ASSERTIONS
    a_rem_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.op == OP_REDUCE && r_mod != '0) |-> (r_rem < {1'b0, r_mod}))
        else $error("remainder not below modulus");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_pc == PC_RED_B || r_pc == PC_EMIT))
        else $error("bad step after accepting an item");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(uw.op == OP_EMIT))
        else $error("result raised outside the emit step");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.op == OP_REDUCE) |-> (r_cnt <= RED_LAST))
        else $error("reduction counter overran");
`endif

endmodule
